/* rtl/stack_bytecode_core_step_top_macros.svh */
// Assertion macros used by the core top module.
`ifndef STACK_BYTECODE_CORE_STEP_TOP_MACROS_SVH
`define STACK_BYTECODE_CORE_STEP_TOP_MACROS_SVH
// Implication checked every clock outside reset.
`define SBC_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define SBC_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* rtl/sbcs_pkg.sv */
// ----------------------------------------------------------------------------
// sbcs_pkg
// Types, constants and codes of the stack bytecode core.
// ----------------------------------------------------------------------------
package sbcs_pkg;
  localparam int CODE_BYTES_DEF = 4096;
  localparam int DSTACK_DEPTH_DEF = 64;
  localparam int RSTACK_DEPTH_DEF = 32;

  localparam logic [2:0] ST_RUN = 3'd0;
  localparam logic [2:0] ST_TOP_RETURN = 3'd1;
  localparam logic [2:0] ST_END_OF_CODE = 3'd2;
  localparam logic [2:0] ST_BAD_OPCODE = 3'd3;
  localparam logic [2:0] ST_STACK_ERROR = 3'd4;
  localparam logic [2:0] ST_DIV_ZERO = 3'd5;
  localparam logic [2:0] ST_UNSUPPORTED = 3'd6;

  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_START = 2'd2;
  localparam logic [1:0] KIND_STEP = 2'd3;

  localparam logic [7:0] OP_NOP = 8'd0;
  localparam logic [7:0] OP_ADD = 8'd1;
  localparam logic [7:0] OP_SUB = 8'd2;
  localparam logic [7:0] OP_MUL = 8'd3;
  localparam logic [7:0] OP_DIV = 8'd4;
  localparam logic [7:0] OP_MOD = 8'd5;
  localparam logic [7:0] OP_SHR = 8'd6;
  localparam logic [7:0] OP_SHL = 8'd7;
  localparam logic [7:0] OP_GT = 8'd9;
  localparam logic [7:0] OP_LT = 8'd10;
  localparam logic [7:0] OP_GE = 8'd11;
  localparam logic [7:0] OP_LE = 8'd12;
  localparam logic [7:0] OP_EQ = 8'd13;
  localparam logic [7:0] OP_NEQ = 8'd14;
  localparam logic [7:0] OP_JMP = 8'd16;
  localparam logic [7:0] OP_CALL = 8'd18;
  localparam logic [7:0] OP_BRT = 8'd20;
  localparam logic [7:0] OP_BRF = 8'd22;
  localparam logic [7:0] OP_RET = 8'd23;
  localparam logic [7:0] OP_LDMOD = 8'd24;
  localparam logic [7:0] OP_EXTERN = 8'd25;
  localparam logic [7:0] OP_LDW = 8'd26;
  localparam logic [7:0] OP_STW = 8'd27;
  localparam logic [7:0] OP_PUSH = 8'd28;
  localparam logic [7:0] OP_DUP = 8'd29;
  localparam logic [7:0] OP_SWAP = 8'd30;
  localparam logic [7:0] OP_DROP = 8'd31;
  localparam logic [7:0] OP_RPUSH = 8'd38;
  localparam logic [7:0] OP_RPOP = 8'd39;
  localparam logic [7:0] OP_RCOPY = 8'd40;
  localparam logic [7:0] OP_INC = 8'd41;
  localparam logic [7:0] OP_RCOPY2 = 8'd43;
  localparam logic [7:0] OP_LDB = 8'd44;
  localparam logic [7:0] OP_STB = 8'd45;

  typedef enum logic [2:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_SHR, ALU_SHL, ALU_CMP, ALU_DIVSTEP
  } alu_op_t;

  typedef struct packed {
    alu_op_t    op;
    logic [7:0] cmp_op;
  } alu_ctl_t;

  typedef enum logic [4:0] {
    S_IDLE, S_MEMWAIT, S_READOUT, S_FETCH_OP, S_DECODE, S_FETCH_LO, S_FETCH_HI,
    S_IMM_DONE, S_POP_B, S_POP_A, S_ALU, S_DIV, S_DIV_DONE, S_WRITE_RES,
    S_LOAD_LO, S_LOAD_HI, S_LOAD_DONE, S_STORE_LO, S_STORE_HI, S_RREAD,
    S_RREAD2, S_RDONE, S_PUSH2, S_REPORT, S_TOPREAD, S_TOPWAIT
  } state_t;
endpackage

/* rtl/stack_bytecode_core_step_top.sv */
// Div and mod run as 16 divide steps of the shared ALU.
// One item at a time: busy stays high until the result strobe.
// The core memory, data and return stacks are single-port RAMs with registered read.
// Synchronous active-high reset clears pc, depths, status and code_length.
// ----------------------------------------------------------------------------
// stack_bytecode_core_step_top
// Dual-stack 16-bit bytecode core, one item per start command.
// ----------------------------------------------------------------------------
`include "stack_bytecode_core_step_top_macros.svh"
module stack_bytecode_core_step_top #(
  parameter int CODE_BYTES = sbcs_pkg::CODE_BYTES_DEF,
  parameter int DATA_STACK_DEPTH = sbcs_pkg::DSTACK_DEPTH_DEF,
  parameter int RETURN_STACK_DEPTH = sbcs_pkg::RSTACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [11:0] address,
  input  logic [7:0]  write_data,
  output logic        done,
  output logic [2:0]  status,
  output logic [15:0] program_counter,
  output logic [15:0] top_of_stack,
  output logic [6:0]  stack_depth,
  output logic [7:0]  read_byte
);
  localparam int CAW = $clog2(CODE_BYTES);
  localparam int DAW = $clog2(DATA_STACK_DEPTH);
  localparam int RAW = $clog2(RETURN_STACK_DEPTH);
  localparam int DDW = $clog2(DATA_STACK_DEPTH + 1);
  localparam int RDW = $clog2(RETURN_STACK_DEPTH + 1);

  sbcs_pkg::state_t state, state_next;
  logic [12:0]    code_length;
  logic [1:0]     kind_r;
  logic [11:0]    addr_r;
  logic [7:0]     wdata_r;
  logic [15:0]    pc, pc_next;
  logic [DDW-1:0] ddepth, ddepth_next;
  logic [RDW-1:0] rdepth, rdepth_next;
  logic [2:0]     hstat, hstat_next;
  logic [7:0]     opc, opc_next;
  logic [15:0]    imm, imm_next;
  logic [15:0]    ra, ra_next, rb, rb_next;
  logic [15:0]    rem, rem_next, quo, quo_next;
  logic [4:0]     cnt, cnt_next;
  logic [7:0]     rbyte, rbyte_next;

  logic           cm_we, ds_we, rs_we;
  logic [CAW-1:0] cm_addr;
  logic [7:0]     cm_wdata, cm_rdata;
  logic [DAW-1:0] ds_addr;
  logic [15:0]    ds_wdata, ds_rdata;
  logic [RAW-1:0] rs_addr;
  logic [15:0]    rs_wdata, rs_rdata;

  sbcs_pkg::alu_ctl_t actl;
  logic [15:0] alu_res, alu_rem, alu_quo;

  sbcs_ram #(.WIDTH(8), .DEPTH(CODE_BYTES)) u_code (
    .clk(clk), .we(cm_we), .addr(cm_addr), .wdata(cm_wdata), .rdata(cm_rdata));
  sbcs_ram #(.WIDTH(16), .DEPTH(DATA_STACK_DEPTH)) u_dstk (
    .clk(clk), .we(ds_we), .addr(ds_addr), .wdata(ds_wdata), .rdata(ds_rdata));
  sbcs_ram #(.WIDTH(16), .DEPTH(RETURN_STACK_DEPTH)) u_rstk (
    .clk(clk), .we(rs_we), .addr(rs_addr), .wdata(rs_wdata), .rdata(rs_rdata));

  sbcs_alu u_alu (
    .ctl(actl), .a(ra), .b(rb), .rem_in(rem), .quo_in(quo),
    .result(alu_res), .rem_out(alu_rem), .quo_out(alu_quo));

  assign pready = 1'b1;
  assign prdata = {19'd0, code_length};
  assign busy = (state != sbcs_pkg::S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      code_length <= 13'd0;
    end else if (psel && penable && pwrite && paddr == 1'b0) begin
      code_length <= pwdata[12:0];
    end
  end

  // room checks in the decode and immediate-done states
  logic [DDW+1:0] dd_ext;
  logic [RDW+1:0] rd_ext;
  logic [1:0] need_dpop, need_dpush, need_rpop, need_rpush;
  logic room_ok, has_imm, known;
  always_comb begin
    dd_ext = (DDW+2)'(ddepth);
    rd_ext = (RDW+2)'(rdepth);
    need_dpop = 2'd0; need_dpush = 2'd0; need_rpop = 2'd0; need_rpush = 2'd0;
    has_imm = 1'b0; known = 1'b1;
    case (opc) inside
      sbcs_pkg::OP_NOP, sbcs_pkg::OP_RET, sbcs_pkg::OP_LDMOD,
      sbcs_pkg::OP_EXTERN, sbcs_pkg::OP_JMP: ;
      [sbcs_pkg::OP_ADD:sbcs_pkg::OP_SHL], [sbcs_pkg::OP_GT:sbcs_pkg::OP_NEQ]: begin
        need_dpop = 2'd2; need_dpush = 2'd1;
      end
      sbcs_pkg::OP_CALL: need_rpush = 2'd1;
      sbcs_pkg::OP_BRT, sbcs_pkg::OP_BRF: need_dpop = 2'd1;
      sbcs_pkg::OP_LDW, sbcs_pkg::OP_INC, sbcs_pkg::OP_LDB: begin
        need_dpop = 2'd1; need_dpush = 2'd1;
      end
      sbcs_pkg::OP_STW, sbcs_pkg::OP_STB: need_dpop = 2'd2;
      sbcs_pkg::OP_PUSH: need_dpush = 2'd1;
      sbcs_pkg::OP_DUP: begin need_dpop = 2'd1; need_dpush = 2'd2; end
      sbcs_pkg::OP_SWAP: begin need_dpop = 2'd2; need_dpush = 2'd2; end
      sbcs_pkg::OP_DROP: need_dpop = 2'd1;
      sbcs_pkg::OP_RPUSH: begin need_dpop = 2'd1; need_rpush = 2'd1; end
      sbcs_pkg::OP_RPOP: begin need_dpush = 2'd1; need_rpop = 2'd1; end
      sbcs_pkg::OP_RCOPY: begin
        need_dpush = 2'd1; need_rpop = 2'd1; need_rpush = 2'd1;
      end
      sbcs_pkg::OP_RCOPY2: begin
        need_dpush = 2'd2; need_rpop = 2'd2; need_rpush = 2'd2;
      end
      default: known = 1'b0;
    endcase
    if (opc == sbcs_pkg::OP_JMP || opc == sbcs_pkg::OP_CALL || opc == sbcs_pkg::OP_BRT ||
        opc == sbcs_pkg::OP_BRF || opc == sbcs_pkg::OP_PUSH) begin
      has_imm = 1'b1;
    end
    room_ok = (dd_ext >= (DDW+2)'(need_dpop)) &&
              (dd_ext - (DDW+2)'(need_dpop) + (DDW+2)'(need_dpush) <=
               (DDW+2)'(DATA_STACK_DEPTH)) &&
              (rd_ext >= (RDW+2)'(need_rpop)) &&
              (rd_ext - (RDW+2)'(need_rpop) + (RDW+2)'(need_rpush) <=
               (RDW+2)'(RETURN_STACK_DEPTH));
  end

  logic [DAW-1:0] dtop, dsec;
  logic [RAW-1:0] rtop, rsec, rnew;
  assign dtop = DAW'(ddepth - DDW'(1));
  assign dsec = DAW'(ddepth - DDW'(2));
  assign rtop = RAW'(rdepth - RDW'(1));
  assign rsec = RAW'(rdepth - RDW'(2));
  assign rnew = RAW'(rdepth);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbcs_pkg::S_IDLE;
      pc <= 16'd0;
      ddepth <= '0;
      rdepth <= '0;
      hstat <= sbcs_pkg::ST_RUN;
    end else begin
      state <= state_next;
      pc <= pc_next;
      ddepth <= ddepth_next;
      rdepth <= rdepth_next;
      hstat <= hstat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r <= kind;
      addr_r <= address;
      wdata_r <= write_data;
    end
    opc <= opc_next; imm <= imm_next; ra <= ra_next; rb <= rb_next;
    rem <= rem_next; quo <= quo_next; cnt <= cnt_next; rbyte <= rbyte_next;
  end

  always_comb begin
    state_next = state;
    pc_next = pc; ddepth_next = ddepth; rdepth_next = rdepth; hstat_next = hstat;
    opc_next = opc; imm_next = imm; ra_next = ra; rb_next = rb;
    rem_next = rem; quo_next = quo; cnt_next = cnt; rbyte_next = rbyte;
    cm_we = 1'b0; cm_addr = CAW'(pc); cm_wdata = wdata_r;
    ds_we = 1'b0; ds_addr = dtop; ds_wdata = ra;
    rs_we = 1'b0; rs_addr = rtop; rs_wdata = pc;
    actl.op = sbcs_pkg::ALU_ADD; actl.cmp_op = opc;
    done = 1'b0;
    unique case (state)
      sbcs_pkg::S_IDLE: begin
        rbyte_next = 8'd0;
        if (start) begin
          unique case (kind)
            sbcs_pkg::KIND_WRITE: begin
              cm_we = 1'b1; cm_addr = CAW'(address); cm_wdata = write_data;
              state_next = sbcs_pkg::S_TOPREAD;
            end
            sbcs_pkg::KIND_READ: begin
              cm_addr = CAW'(address);
              state_next = sbcs_pkg::S_READOUT;
            end
            sbcs_pkg::KIND_START: begin
              pc_next = 16'(address); ddepth_next = '0; rdepth_next = '0;
              hstat_next = sbcs_pkg::ST_RUN;
              state_next = sbcs_pkg::S_TOPREAD;
            end
            default: begin
              if (hstat != sbcs_pkg::ST_RUN) begin
                state_next = sbcs_pkg::S_TOPREAD;
              end else if (pc >= 16'(code_length)) begin
                hstat_next = sbcs_pkg::ST_END_OF_CODE;
                state_next = sbcs_pkg::S_TOPREAD;
              end else begin
                state_next = sbcs_pkg::S_FETCH_OP;
                pc_next = pc + 16'd1;
              end
            end
          endcase
        end
      end
      sbcs_pkg::S_READOUT: begin
        rbyte_next = cm_rdata;
        state_next = sbcs_pkg::S_TOPREAD;
      end
      sbcs_pkg::S_FETCH_OP: begin
        // code read of old pc issued in idle cycle
        opc_next = cm_rdata;
        state_next = sbcs_pkg::S_DECODE;
      end
      sbcs_pkg::S_DECODE: begin
        if (!known) begin
          hstat_next = sbcs_pkg::ST_BAD_OPCODE;
          state_next = sbcs_pkg::S_TOPREAD;
        end else if (opc == sbcs_pkg::OP_LDMOD || opc == sbcs_pkg::OP_EXTERN) begin
          hstat_next = sbcs_pkg::ST_UNSUPPORTED;
          state_next = sbcs_pkg::S_TOPREAD;
        end else if (has_imm) begin
          pc_next = pc + 16'd1;
          state_next = sbcs_pkg::S_FETCH_LO;
        end else if (opc == sbcs_pkg::OP_RET && rdepth == '0) begin
          hstat_next = sbcs_pkg::ST_TOP_RETURN;
          state_next = sbcs_pkg::S_TOPREAD;
        end else if (!room_ok) begin
          hstat_next = sbcs_pkg::ST_STACK_ERROR;
          state_next = sbcs_pkg::S_TOPREAD;
        end else begin
          unique case (opc) inside
            sbcs_pkg::OP_NOP: state_next = sbcs_pkg::S_TOPREAD;
            sbcs_pkg::OP_RET, sbcs_pkg::OP_RPOP, sbcs_pkg::OP_RCOPY,
            sbcs_pkg::OP_RCOPY2: begin
              rs_addr = rtop;
              state_next = sbcs_pkg::S_RREAD;
            end
            default: begin
              ds_addr = dtop;
              state_next = sbcs_pkg::S_POP_B;
            end
          endcase
        end
      end
      sbcs_pkg::S_FETCH_LO: begin
        imm_next[7:0] = cm_rdata;
        pc_next = pc + 16'd1;
        state_next = sbcs_pkg::S_FETCH_HI;
      end
      sbcs_pkg::S_FETCH_HI: begin
        imm_next[15:8] = cm_rdata;
        state_next = sbcs_pkg::S_IMM_DONE;
      end
      sbcs_pkg::S_IMM_DONE: begin
        if (!room_ok) begin
          hstat_next = sbcs_pkg::ST_STACK_ERROR;
          state_next = sbcs_pkg::S_TOPREAD;
        end else begin
          unique case (opc)
            sbcs_pkg::OP_JMP: begin
              pc_next = imm; state_next = sbcs_pkg::S_TOPREAD;
            end
            sbcs_pkg::OP_CALL: begin
              rs_we = 1'b1; rs_addr = rnew; rs_wdata = pc;
              rdepth_next = rdepth + RDW'(1);
              pc_next = imm; state_next = sbcs_pkg::S_TOPREAD;
            end
            sbcs_pkg::OP_PUSH: begin
              ds_we = 1'b1; ds_addr = DAW'(ddepth); ds_wdata = imm;
              ddepth_next = ddepth + DDW'(1);
              state_next = sbcs_pkg::S_TOPREAD;
            end
            default: begin
              ds_addr = dtop; state_next = sbcs_pkg::S_POP_B;
            end
          endcase
        end
      end
      sbcs_pkg::S_POP_B: begin
        rb_next = ds_rdata;
        ds_addr = dsec;
        unique case (opc)
          sbcs_pkg::OP_BRT, sbcs_pkg::OP_BRF: begin
            ddepth_next = ddepth - DDW'(1);
            if ((ds_rdata != 16'd0) == (opc == sbcs_pkg::OP_BRT)) pc_next = imm;
            state_next = sbcs_pkg::S_TOPREAD;
          end
          sbcs_pkg::OP_DROP: begin
            ddepth_next = ddepth - DDW'(1); state_next = sbcs_pkg::S_TOPREAD;
          end
          sbcs_pkg::OP_DUP: begin
            ds_we = 1'b1; ds_addr = DAW'(ddepth); ds_wdata = ds_rdata;
            ddepth_next = ddepth + DDW'(1); state_next = sbcs_pkg::S_TOPREAD;
          end
          sbcs_pkg::OP_RPUSH: begin
            rs_we = 1'b1; rs_addr = rnew; rs_wdata = ds_rdata;
            rdepth_next = rdepth + RDW'(1); ddepth_next = ddepth - DDW'(1);
            state_next = sbcs_pkg::S_TOPREAD;
          end
          sbcs_pkg::OP_INC: begin
            ra_next = ds_rdata; rb_next = 16'd1;
            state_next = sbcs_pkg::S_ALU;
          end
          sbcs_pkg::OP_LDW, sbcs_pkg::OP_LDB: begin
            cm_addr = CAW'(ds_rdata);
            ra_next = ds_rdata;
            state_next = sbcs_pkg::S_LOAD_LO;
          end
          default: begin
            if ((opc == sbcs_pkg::OP_DIV || opc == sbcs_pkg::OP_MOD) &&
                ds_rdata == 16'd0) begin
              hstat_next = sbcs_pkg::ST_DIV_ZERO;
              state_next = sbcs_pkg::S_TOPREAD;
            end else begin
              state_next = sbcs_pkg::S_POP_A;
            end
          end
        endcase
      end
      sbcs_pkg::S_POP_A: begin
        ra_next = ds_rdata;
        unique case (opc) inside
          sbcs_pkg::OP_SWAP: begin
            ds_we = 1'b1; ds_addr = dsec; ds_wdata = rb;
            state_next = sbcs_pkg::S_PUSH2;
          end
          sbcs_pkg::OP_STW, sbcs_pkg::OP_STB: begin
            cm_we = 1'b1; cm_addr = CAW'(rb); cm_wdata = ds_rdata[7:0];
            ddepth_next = ddepth - DDW'(2);
            state_next = (opc == sbcs_pkg::OP_STW) ? sbcs_pkg::S_STORE_HI
                                                   : sbcs_pkg::S_TOPREAD;
          end
          sbcs_pkg::OP_DIV, sbcs_pkg::OP_MOD: begin
            rem_next = 16'd0; quo_next = ds_rdata; cnt_next = 5'd0;
            state_next = sbcs_pkg::S_DIV;
          end
          default: state_next = sbcs_pkg::S_ALU;
        endcase
      end
      sbcs_pkg::S_PUSH2: begin
        ds_we = 1'b1; ds_addr = dtop; ds_wdata = ra;
        state_next = sbcs_pkg::S_TOPREAD;
      end
      sbcs_pkg::S_STORE_HI: begin
        cm_we = 1'b1; cm_addr = CAW'(rb + 16'd1); cm_wdata = ra[15:8];
        state_next = sbcs_pkg::S_TOPREAD;
      end
      sbcs_pkg::S_ALU: begin
        unique case (opc) inside
          sbcs_pkg::OP_ADD, sbcs_pkg::OP_INC: actl.op = sbcs_pkg::ALU_ADD;
          sbcs_pkg::OP_SUB: actl.op = sbcs_pkg::ALU_SUB;
          sbcs_pkg::OP_MUL: actl.op = sbcs_pkg::ALU_MUL;
          sbcs_pkg::OP_SHR: actl.op = sbcs_pkg::ALU_SHR;
          sbcs_pkg::OP_SHL: actl.op = sbcs_pkg::ALU_SHL;
          default: actl.op = sbcs_pkg::ALU_CMP;
        endcase
        ra_next = alu_res;
        state_next = sbcs_pkg::S_WRITE_RES;
      end
      sbcs_pkg::S_DIV: begin
        actl.op = sbcs_pkg::ALU_DIVSTEP;
        rem_next = alu_rem; quo_next = alu_quo;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd15) state_next = sbcs_pkg::S_DIV_DONE;
      end
      sbcs_pkg::S_DIV_DONE: begin
        ra_next = (opc == sbcs_pkg::OP_DIV) ? quo : rem;
        state_next = sbcs_pkg::S_WRITE_RES;
      end
      sbcs_pkg::S_WRITE_RES: begin
        ds_we = 1'b1; ds_wdata = ra;
        if (opc == sbcs_pkg::OP_INC) begin
          ds_addr = dtop;
        end else begin
          ds_addr = dsec; ddepth_next = ddepth - DDW'(1);
        end
        state_next = sbcs_pkg::S_TOPREAD;
      end
      sbcs_pkg::S_LOAD_LO: begin
        cm_addr = CAW'(ra + 16'd1);
        if (opc == sbcs_pkg::OP_LDB) begin
          ra_next = {8'd0, cm_rdata};
          state_next = sbcs_pkg::S_LOAD_DONE;
        end else begin
          rb_next = {8'd0, cm_rdata};
          state_next = sbcs_pkg::S_LOAD_HI;
        end
      end
      sbcs_pkg::S_LOAD_HI: begin
        ra_next = {cm_rdata, rb[7:0]};
        state_next = sbcs_pkg::S_LOAD_DONE;
      end
      sbcs_pkg::S_LOAD_DONE: begin
        ds_we = 1'b1; ds_addr = dtop; ds_wdata = ra;
        state_next = sbcs_pkg::S_TOPREAD;
      end
      sbcs_pkg::S_RREAD: begin
        ra_next = rs_rdata;
        rs_addr = rsec;
        unique case (opc)
          sbcs_pkg::OP_RET: begin
            pc_next = rs_rdata; rdepth_next = rdepth - RDW'(1);
            state_next = sbcs_pkg::S_TOPREAD;
          end
          sbcs_pkg::OP_RPOP, sbcs_pkg::OP_RCOPY: begin
            ds_we = 1'b1; ds_addr = DAW'(ddepth); ds_wdata = rs_rdata;
            ddepth_next = ddepth + DDW'(1);
            if (opc == sbcs_pkg::OP_RPOP) rdepth_next = rdepth - RDW'(1);
            state_next = sbcs_pkg::S_TOPREAD;
          end
          default: state_next = sbcs_pkg::S_RREAD2;
        endcase
      end
      sbcs_pkg::S_RREAD2: begin
        ds_we = 1'b1; ds_addr = DAW'(ddepth); ds_wdata = rs_rdata;
        state_next = sbcs_pkg::S_RDONE;
      end
      sbcs_pkg::S_RDONE: begin
        ds_we = 1'b1; ds_addr = DAW'(ddepth + DDW'(1)); ds_wdata = ra;
        ddepth_next = ddepth + DDW'(2);
        state_next = sbcs_pkg::S_TOPREAD;
      end
      sbcs_pkg::S_TOPREAD: begin
        ds_addr = dtop;
        state_next = sbcs_pkg::S_TOPWAIT;
      end
      sbcs_pkg::S_TOPWAIT: begin
        ds_addr = dtop;
        state_next = sbcs_pkg::S_REPORT;
      end
      sbcs_pkg::S_REPORT: begin
        done = 1'b1;
        state_next = sbcs_pkg::S_IDLE;
      end
      default: state_next = sbcs_pkg::S_IDLE;
    endcase
  end

  logic [15:0] top_q;
  always_ff @(posedge clk) begin
    if (state == sbcs_pkg::S_TOPWAIT) top_q <= ds_rdata;
  end

  assign status = hstat;
  assign program_counter = pc;
  assign top_of_stack = (ddepth == '0) ? 16'd0 : top_q;
  assign stack_depth = 7'(ddepth);
  assign read_byte = rbyte;

  `SBC_ASSERT_IMPL(a_depth_bound, clk, rst, 1'b1, ddepth <= DDW'(DATA_STACK_DEPTH))
  `SBC_ASSERT_IMPL(a_rdepth_bound, clk, rst, 1'b1, rdepth <= RDW'(RETURN_STACK_DEPTH))
  `SBC_ASSERT_NEXT(a_done_idle, clk, rst, done, !busy)
  `SBC_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
endmodule

/* rtl/sbcs_ram.sv */
// ----------------------------------------------------------------------------
// sbcs_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module sbcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* rtl/sbcs_alu.sv */
// ----------------------------------------------------------------------------
// sbcs_alu
// Shared 16-bit arithmetic unit: add, sub, mul, shifts, compares and one
// restoring-divide step per use.
// ----------------------------------------------------------------------------
module sbcs_alu (
  input  sbcs_pkg::alu_ctl_t ctl,
  input  logic [15:0]        a,
  input  logic [15:0]        b,
  input  logic [15:0]        rem_in,
  input  logic [15:0]        quo_in,
  output logic [15:0]        result,
  output logic [15:0]        rem_out,
  output logic [15:0]        quo_out
);
  logic [16:0] trial;
  logic [31:0] prod;
  logic        cmp;

  always_comb begin
    trial = {rem_in, quo_in[15]} - {1'b0, b};
    prod = 32'(a) * 32'(b);
    rem_out = rem_in;
    quo_out = quo_in;
    cmp = 1'b0;
    case (ctl.cmp_op)
      sbcs_pkg::OP_GT: cmp = a > b;
      sbcs_pkg::OP_LT: cmp = a < b;
      sbcs_pkg::OP_GE: cmp = a >= b;
      sbcs_pkg::OP_LE: cmp = a <= b;
      sbcs_pkg::OP_EQ: cmp = a == b;
      default:         cmp = a != b;
    endcase
    case (ctl.op)
      sbcs_pkg::ALU_ADD: result = a + b;
      sbcs_pkg::ALU_SUB: result = a - b;
      sbcs_pkg::ALU_MUL: result = prod[15:0];
      sbcs_pkg::ALU_SHR: result = (b[15:4] != 12'd0) ? 16'd0 : (a >> b[3:0]);
      sbcs_pkg::ALU_SHL: result = (b[15:4] != 12'd0) ? 16'd0 : (a << b[3:0]);
      sbcs_pkg::ALU_CMP: result = {15'd0, cmp};
      default: begin
        result = 16'd0;
        if (!trial[16]) begin
          rem_out = trial[15:0];
          quo_out = {quo_in[14:0], 1'b1};
        end else begin
          rem_out = {rem_in[14:0], quo_in[15]};
          quo_out = {quo_in[14:0], 1'b0};
        end
      end
    endcase
  end
endmodule
